### src/rwt_pkg.sv
//------------------------------------------------------------------------------
// rwt_pkg
// shared constants, codes and types of the wall texture column unit
//------------------------------------------------------------------------------
`default_nettype none

package rwt_pkg;

    localparam int FRAC_BITS    = 16;
    localparam int MAX_TEX_LOG2 = 10;
    localparam int COORD_BITS   = 12;

    localparam int POS_BITS  = FRAC_BITS + 16;
    localparam int STEP_BITS = FRAC_BITS + MAX_TEX_LOG2 + 2;
    localparam int UNIT_W    = (2 * FRAC_BITS > POS_BITS) ? 2 * FRAC_BITS : POS_BITS;
    localparam int CNT_W     = $clog2(UNIT_W);

    localparam int TW_W   = MAX_TEX_LOG2 + 1;
    localparam int TW_MAX = 1 << MAX_TEX_LOG2;
    localparam int LOG_W  = $clog2(MAX_TEX_LOG2 + 1);

    localparam int SW_W       = 12;
    localparam int SH_W       = 12;
    localparam int TEXW_REG_W = 11;
    localparam int TLOG_REG_W = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    localparam int PIX_W   = 24;
    localparam int TEXEL_W = 20;

    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TEX_WIDTH     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TEX_LOG2      = 2'd3;

    localparam logic ACT_BEGIN = 1'b0;
    localparam logic ACT_ROW   = 1'b1;

    localparam logic [1:0] TEX_WEST  = 2'd0;
    localparam logic [1:0] TEX_EAST  = 2'd1;
    localparam logic [1:0] TEX_NORTH = 2'd2;
    localparam logic [1:0] TEX_SOUTH = 2'd3;

    typedef enum logic {
        OP_MUL,
        OP_DIV
    } unit_op_t;

    typedef struct packed {
        logic     start;
        unit_op_t op;
    } unit_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

    typedef struct packed {
        logic [SW_W-1:0]  screen_width;
        logic [SH_W-1:0]  screen_height;
        logic [TW_W-1:0]  tex_width;
        logic [LOG_W-1:0] tex_log2;
    } cfg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_HIT_GO,
        ST_HIT_WAIT,
        ST_COL_GO,
        ST_COL_WAIT,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_POS_GO,
        ST_POS_WAIT
    } seq_state_t;

endpackage

`default_nettype wire

### src/rwt_cfg_regs.sv
//------------------------------------------------------------------------------
// rwt_cfg_regs
// configuration registers with range clamping of the texture size
//------------------------------------------------------------------------------
`default_nettype none

module rwt_cfg_regs (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_valid,
    input  wire logic [rwt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [rwt_pkg::CFG_DATA_W-1:0] cfg_data,
    output rwt_pkg::cfg_t                       cfg
);

    logic [rwt_pkg::SW_W-1:0]       screen_width_reg;
    logic [rwt_pkg::SH_W-1:0]       screen_height_reg;
    logic [rwt_pkg::TEXW_REG_W-1:0] tex_width_reg;
    logic [rwt_pkg::TLOG_REG_W-1:0] tex_log2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            screen_width_reg  <= rwt_pkg::SW_W'(640);
            screen_height_reg <= rwt_pkg::SH_W'(480);
            tex_width_reg     <= rwt_pkg::TEXW_REG_W'(64);
            tex_log2_reg      <= rwt_pkg::TLOG_REG_W'(6);
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                rwt_pkg::CFG_SCREEN_WIDTH:
                    screen_width_reg <= cfg_data[rwt_pkg::SW_W-1:0];
                rwt_pkg::CFG_SCREEN_HEIGHT:
                    screen_height_reg <= cfg_data[rwt_pkg::SH_W-1:0];
                rwt_pkg::CFG_TEX_WIDTH:
                    tex_width_reg <= cfg_data[rwt_pkg::TEXW_REG_W-1:0];
                rwt_pkg::CFG_TEX_LOG2:
                    tex_log2_reg <= cfg_data[rwt_pkg::TLOG_REG_W-1:0];
                default:
                    screen_width_reg <= screen_width_reg;
            endcase
        end
    end

    always_comb
    begin
        cfg.screen_width  = screen_width_reg;
        cfg.screen_height = screen_height_reg;
        if (tex_width_reg == '0)
            cfg.tex_width = rwt_pkg::TW_W'(1);
        else if (32'(tex_width_reg) > rwt_pkg::TW_MAX)
            cfg.tex_width = rwt_pkg::TW_W'(rwt_pkg::TW_MAX);
        else
            cfg.tex_width = rwt_pkg::TW_W'(tex_width_reg);
        if (32'(tex_log2_reg) > rwt_pkg::MAX_TEX_LOG2)
            cfg.tex_log2 = rwt_pkg::LOG_W'(rwt_pkg::MAX_TEX_LOG2);
        else
            cfg.tex_log2 = rwt_pkg::LOG_W'(tex_log2_reg);
    end

endmodule

`default_nettype wire

### src/rwt_serial_unit.sv
//------------------------------------------------------------------------------
// rwt_serial_unit
// bit-serial shift-add multiplier and restoring divider on one shared adder
//------------------------------------------------------------------------------
`default_nettype none

module rwt_serial_unit (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire rwt_pkg::unit_req_t         req,
    input  wire logic [rwt_pkg::UNIT_W-1:0] opa,
    input  wire logic [rwt_pkg::UNIT_W-1:0] opb,
    output rwt_pkg::unit_stat_t             stat,
    output logic [rwt_pkg::UNIT_W-1:0]      result
);

    localparam int W = rwt_pkg::UNIT_W;

    logic [W-1:0]              acc_reg;
    logic [W-1:0]              a_reg;
    logic [W-1:0]              b_reg;
    logic [rwt_pkg::CNT_W-1:0] cnt_reg;
    rwt_pkg::unit_op_t         op_reg;
    logic                      busy_reg;
    logic                      done_reg;

    logic         is_div;
    logic [W-1:0] rem_shift;
    logic [W-1:0] add_x;
    logic [W-1:0] add_y;
    logic [W:0]   sum;
    logic         ge;

    // one adder: accumulate for multiply, trial subtract for divide
    always_comb
    begin
        is_div    = (op_reg == rwt_pkg::OP_DIV);
        rem_shift = {acc_reg[W-2:0], b_reg[W-1]};
        add_x     = is_div ? rem_shift : acc_reg;
        add_y     = is_div ? ~a_reg : a_reg;
        sum       = {1'b0, add_x} + {1'b0, add_y} + {{W{1'b0}}, is_div};
        ge        = sum[W];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            op_reg   <= rwt_pkg::OP_MUL;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start && !busy_reg)
            begin
                busy_reg <= 1'b1;
                op_reg   <= req.op;
                cnt_reg  <= rwt_pkg::CNT_W'(W - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - rwt_pkg::CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start && !busy_reg)
        begin
            acc_reg <= '0;
            a_reg   <= opa;
            b_reg   <= opb;
        end
        else if (busy_reg)
        begin
            if (is_div)
            begin
                acc_reg <= ge ? sum[W-1:0] : rem_shift;
                b_reg   <= {b_reg[W-2:0], ge};
            end
            else
            begin
                if (b_reg[0])
                    acc_reg <= sum[W-1:0];
                a_reg <= {a_reg[W-2:0], 1'b0};
                b_reg <= {1'b0, b_reg[W-1:1]};
            end
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign result    = is_div ? b_reg : acc_reg;

endmodule

`default_nettype wire

### src/raycast_wall_texture_column_unit.sv
//------------------------------------------------------------------------------
// raycast_wall_texture_column_unit
// begin item: runs the hit multiply, column multiply, step divide and position
//   multiply in turn on the serial multiply/divide unit; no input is taken meanwhile
// throughput: one row item per cycle while the output is taken and no begin item
//   is in progress; a row result appears in the cycle after its item is accepted
// reset: asynchronous, active low; state clears to zero, registers to
//   640, 480, 64, 6
//------------------------------------------------------------------------------
`default_nettype none

module raycast_wall_texture_column_unit (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [rwt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [rwt_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic                           action,
    input  wire logic [11:0]                    column,
    input  wire logic                           side,
    input  wire logic [23:0]                    pos_x,
    input  wire logic [23:0]                    pos_y,
    input  wire logic signed [18:0]             ray_dir_x,
    input  wire logic signed [18:0]             ray_dir_y,
    input  wire logic [25:0]                    wall_dist,
    input  wire logic [11:0]                    slice_first,
    input  wire logic [11:0]                    slice_limit,
    input  wire logic [15:0]                    line_height,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [rwt_pkg::PIX_W-1:0]           pixel_index,
    output logic [1:0]                          texture_select,
    output logic [rwt_pkg::TEXEL_W-1:0]         texel_index,
    output logic                                last_row
);

    localparam int F  = rwt_pkg::FRAC_BITS;
    localparam int W  = rwt_pkg::UNIT_W;
    localparam int CB = rwt_pkg::COORD_BITS;
    localparam int MT = rwt_pkg::MAX_TEX_LOG2;

    rwt_pkg::cfg_t       cfg;
    rwt_pkg::unit_req_t  unit_req;
    rwt_pkg::unit_stat_t unit_stat;
    logic [W-1:0]        unit_a;
    logic [W-1:0]        unit_b;
    logic [W-1:0]        unit_result;

    rwt_pkg::seq_state_t state_reg;
    rwt_pkg::seq_state_t state_next;

    logic                           mirror_reg;
    logic [F-1:0]                   pos_frac_reg;
    logic [F-1:0]                   frac_reg;
    logic signed [18:0]             dir_reg;
    logic [25:0]                    dist_reg;
    logic [15:0]                    lh_reg;
    logic [W-1:0]                   start_reg;
    logic [CB-1:0]                  row_reg;
    logic [CB-1:0]                  row_end_reg;
    logic [CB-1:0]                  col_reg;
    logic [rwt_pkg::POS_BITS-1:0]   tex_pos_reg;
    logic [rwt_pkg::STEP_BITS-1:0]  tex_step_reg;
    logic [MT-1:0]                  tex_column_reg;
    logic [1:0]                     chosen_reg;

    logic                           out_valid_reg;
    logic [rwt_pkg::PIX_W-1:0]      pixel_reg;
    logic [rwt_pkg::TEXEL_W-1:0]    texel_reg;
    logic                           last_reg;

    logic                           in_fire;
    logic                           begin_fire;
    logic                           row_fire;
    logic                           emit;
    logic [15:0]                    lh_eff;
    logic [MT-1:0]                  trow_mask;
    logic [MT-1:0]                  trow;
    logic [rwt_pkg::PIX_W-1:0]      pixel_calc;
    logic [rwt_pkg::TEXEL_W-1:0]    texel_calc;
    logic [rwt_pkg::TW_W-1:0]       tx;
    logic [rwt_pkg::TW_W-1:0]       tcol_full;

    rwt_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    rwt_serial_unit u_unit (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (unit_req),
        .opa    (unit_a),
        .opb    (unit_b),
        .stat   (unit_stat),
        .result (unit_result)
    );

    assign cfg_ready  = 1'b1;
    assign in_ready   = (state_reg == rwt_pkg::ST_IDLE) && (!out_valid_reg || out_ready);
    assign in_fire    = in_valid && in_ready;
    assign begin_fire = in_fire && (action == rwt_pkg::ACT_BEGIN);
    assign row_fire   = in_fire && (action == rwt_pkg::ACT_ROW);
    assign emit       = row_fire && (row_reg < row_end_reg);
    assign lh_eff     = (line_height == '0) ? 16'd1 : line_height;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rwt_pkg::ST_IDLE:
                if (begin_fire)
                    state_next = rwt_pkg::ST_HIT_GO;
            rwt_pkg::ST_HIT_GO:
                state_next = rwt_pkg::ST_HIT_WAIT;
            rwt_pkg::ST_HIT_WAIT:
                if (unit_stat.done)
                    state_next = rwt_pkg::ST_COL_GO;
            rwt_pkg::ST_COL_GO:
                state_next = rwt_pkg::ST_COL_WAIT;
            rwt_pkg::ST_COL_WAIT:
                if (unit_stat.done)
                    state_next = rwt_pkg::ST_DIV_GO;
            rwt_pkg::ST_DIV_GO:
                state_next = rwt_pkg::ST_DIV_WAIT;
            rwt_pkg::ST_DIV_WAIT:
                if (unit_stat.done)
                    state_next = rwt_pkg::ST_POS_GO;
            rwt_pkg::ST_POS_GO:
                state_next = rwt_pkg::ST_POS_WAIT;
            rwt_pkg::ST_POS_WAIT:
                if (unit_stat.done)
                    state_next = rwt_pkg::ST_IDLE;
            default:
                state_next = rwt_pkg::ST_IDLE;
        endcase
    end

    // unit requests
    always_comb
    begin
        unit_req.start = 1'b0;
        unit_req.op    = rwt_pkg::OP_MUL;
        unit_a         = '0;
        unit_b         = '0;
        case (state_reg)
            rwt_pkg::ST_HIT_GO:
            begin
                unit_req.start = 1'b1;
                unit_a         = W'(dir_reg);
                unit_b         = W'(dist_reg);
            end
            rwt_pkg::ST_COL_GO:
            begin
                unit_req.start = 1'b1;
                unit_a         = W'(frac_reg);
                unit_b         = W'(cfg.tex_width);
            end
            rwt_pkg::ST_DIV_GO:
            begin
                unit_req.start = 1'b1;
                unit_req.op    = rwt_pkg::OP_DIV;
                unit_a         = W'(lh_reg);
                unit_b         = W'(1) << (F + 32'(cfg.tex_log2));
            end
            rwt_pkg::ST_POS_GO:
            begin
                unit_req.start = 1'b1;
                unit_a         = start_reg;
                unit_b         = W'(tex_step_reg);
            end
            default:
            begin
                unit_req.start = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        tx         = unit_result[F +: rwt_pkg::TW_W];
        tcol_full  = mirror_reg ? (cfg.tex_width - rwt_pkg::TW_W'(1) - tx) : tx;
        trow_mask  = MT'((32'(1) << cfg.tex_log2) - 1);
        trow       = tex_pos_reg[F +: MT] & trow_mask;
        pixel_calc = rwt_pkg::PIX_W'(cfg.screen_width) * rwt_pkg::PIX_W'(row_reg)
                     + rwt_pkg::PIX_W'(col_reg);
        texel_calc = rwt_pkg::TEXEL_W'(cfg.tex_width) * rwt_pkg::TEXEL_W'(trow)
                     + rwt_pkg::TEXEL_W'(tex_column_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= rwt_pkg::ST_IDLE;
            row_reg        <= '0;
            row_end_reg    <= '0;
            col_reg        <= '0;
            tex_pos_reg    <= '0;
            tex_step_reg   <= '0;
            tex_column_reg <= '0;
            chosen_reg     <= rwt_pkg::TEX_WEST;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (emit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;

            if (begin_fire)
            begin
                row_reg     <= CB'(slice_first);
                row_end_reg <= CB'(slice_limit);
                col_reg     <= CB'(column);
                if (side == 1'b0)
                    chosen_reg <= ray_dir_x[18] ? rwt_pkg::TEX_WEST : rwt_pkg::TEX_EAST;
                else
                    chosen_reg <= ray_dir_y[18] ? rwt_pkg::TEX_NORTH : rwt_pkg::TEX_SOUTH;
            end
            else if (emit)
            begin
                row_reg     <= row_reg + CB'(1);
                tex_pos_reg <= tex_pos_reg + rwt_pkg::POS_BITS'(tex_step_reg);
            end

            if (state_reg == rwt_pkg::ST_COL_WAIT && unit_stat.done)
                tex_column_reg <= tcol_full[MT-1:0];
            if (state_reg == rwt_pkg::ST_DIV_WAIT && unit_stat.done)
                tex_step_reg <= unit_result[rwt_pkg::STEP_BITS-1:0];
            if (state_reg == rwt_pkg::ST_POS_WAIT && unit_stat.done)
                tex_pos_reg <= unit_result[rwt_pkg::POS_BITS-1:0];
        end
    end

    // begin item capture, intermediate results and row outputs
    always_ff @(posedge clk)
    begin
        if (begin_fire)
        begin
            mirror_reg   <= (side == 1'b0) ? (!ray_dir_x[18] && (ray_dir_x != '0))
                                           : ray_dir_y[18];
            pos_frac_reg <= (side == 1'b0) ? pos_y[F-1:0] : pos_x[F-1:0];
            dir_reg      <= (side == 1'b0) ? ray_dir_y : ray_dir_x;
            dist_reg     <= wall_dist;
            lh_reg       <= lh_eff;
            start_reg    <= W'(slice_first) - W'(cfg.screen_height >> 1) + W'(lh_eff >> 1);
        end
        if (state_reg == rwt_pkg::ST_HIT_WAIT && unit_stat.done)
            frac_reg <= pos_frac_reg + unit_result[2*F-1:F];
        if (emit)
        begin
            pixel_reg <= pixel_calc;
            texel_reg <= texel_calc;
            last_reg  <= ((row_reg + CB'(1)) == row_end_reg);
        end
    end

    assign out_valid      = out_valid_reg;
    assign pixel_index    = pixel_reg;
    assign texture_select = chosen_reg;
    assign texel_index    = texel_reg;
    assign last_row       = last_reg;

    a_begin_starts_unit: assert property (@(posedge clk) disable iff (!rst_n)
        begin_fire |=> (state_reg == rwt_pkg::ST_HIT_GO))
        else $error("begin item did not start the hit multiply");

    a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
        unit_stat.busy |-> !in_ready)
        else $error("input ready while the serial unit is busy");

    a_no_emit_past_end: assert property (@(posedge clk) disable iff (!rst_n)
        (row_fire && (row_reg >= row_end_reg)) |=> $stable(row_reg))
        else $error("row advanced past the end of the column");

    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        unit_stat.done |-> (state_reg == rwt_pkg::ST_HIT_WAIT
                            || state_reg == rwt_pkg::ST_COL_WAIT
                            || state_reg == rwt_pkg::ST_DIV_WAIT
                            || state_reg == rwt_pkg::ST_POS_WAIT))
        else $error("unit finished outside a wait state");

endmodule

`default_nettype wire
